// ----- src/pidc_pkg.sv -----
// Shared types and constants for the four-axis PID position controller.
// Used by the register bank, the controller, the datapath and the top level.
// Depends on nothing.
package pidc_pkg;

  localparam int AXES      = 4;
  localparam int FRAC_BITS = 16;
  localparam int AXIS_W    = (AXES > 1) ? $clog2(AXES) : 1;

  localparam int VAL_W  = 32;
  localparam int DT_W   = 31;
  localparam int GAIN_W = 24;
  localparam int LIM_W  = 31;

  localparam int IN_BITS = 2 * AXES * VAL_W + DT_W;
  localparam int IN_W    = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_W   = AXES * VAL_W;

  localparam int PROD_W = 2 * VAL_W;
  localparam int SHP_W  = PROD_W - FRAC_BITS;
  localparam int ACC_W  = SHP_W + 2;
  localparam int DIV_W  = VAL_W + FRAC_BITS;
  localparam int DCNT_W = $clog2(DIV_W + 1);

  localparam longint PI_Q32     = 64'sd13493037705;
  localparam longint TWO_PI_Q32 = 64'sd26986075409;
  localparam longint PI_Q     = (PI_Q32 + (64'sd1 <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
  localparam longint TWO_PI_Q = (TWO_PI_Q32 + (64'sd1 <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);

  localparam int NUM_REGS = 8;
  localparam int CFG_AW   = $clog2(NUM_REGS) + 2;
  localparam int CFG_DW   = 32;

  typedef enum logic [2:0] {
    REG_KP_HORIZONTAL,
    REG_KP_VERTICAL,
    REG_KP_HEADING,
    REG_KI_ALL,
    REG_KD_HORIZONTAL,
    REG_KD_VERTICAL_HEADING,
    REG_INTEGRAL_LIMIT,
    REG_OUTPUT_LIMIT
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp_horizontal;
    logic [GAIN_W-1:0] kp_vertical;
    logic [GAIN_W-1:0] kp_heading;
    logic [GAIN_W-1:0] ki_all;
    logic [GAIN_W-1:0] kd_horizontal;
    logic [GAIN_W-1:0] kd_vertical_heading;
    logic [LIM_W-1:0]  integral_limit;
    logic [LIM_W-1:0]  output_limit;
  } cfg_t;

  typedef enum logic [1:0] {
    MUL_ERR_DT,
    MUL_ERR_KP,
    MUL_INT_KI,
    MUL_DER_KD
  } mul_sel_t;

  typedef struct packed {
    logic              load_in;
    logic              err_cap;
    logic              mul_go;
    mul_sel_t          mul_sel;
    logic              integ_upd;
    logic              div_init;
    logic              div_step;
    logic              deriv_fin;
    logic              acc_load;
    logic              acc_add;
    logic              axis_done;
    logic              out_load;
    logic [AXIS_W-1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic dt_zero;
  } stat_t;

endpackage

// ----- src/pidc_cfg_regs.sv -----
// Gain and limit register bank behind an APB-style write and read port.
// Depends on pidc_pkg for the register indexes and the cfg_t bundle.
module pidc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pidc_pkg::CFG_AW-1:0] paddr,
  input  logic [pidc_pkg::CFG_DW-1:0] pwdata,
  output logic [pidc_pkg::CFG_DW-1:0] prdata,
  output pidc_pkg::cfg_t              cfg
);

  pidc_pkg::cfg_t   cfg_r;
  pidc_pkg::reg_idx_t idx;
  logic             wr_en;

  assign idx   = pidc_pkg::reg_idx_t'(paddr[pidc_pkg::CFG_AW-1:2]);
  assign wr_en = psel && penable && pwrite;
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp_horizontal       <= pidc_pkg::GAIN_W'(131072);
      cfg_r.kp_vertical         <= pidc_pkg::GAIN_W'(65536);
      cfg_r.kp_heading          <= pidc_pkg::GAIN_W'(65536);
      cfg_r.ki_all              <= pidc_pkg::GAIN_W'(3277);
      cfg_r.kd_horizontal       <= pidc_pkg::GAIN_W'(98304);
      cfg_r.kd_vertical_heading <= '0;
      cfg_r.integral_limit      <= pidc_pkg::LIM_W'(65536);
      cfg_r.output_limit        <= pidc_pkg::LIM_W'(65536);
    end else if (wr_en) begin
      unique case (idx)
        pidc_pkg::REG_KP_HORIZONTAL:
          cfg_r.kp_horizontal <= pwdata[pidc_pkg::GAIN_W-1:0];
        pidc_pkg::REG_KP_VERTICAL:
          cfg_r.kp_vertical <= pwdata[pidc_pkg::GAIN_W-1:0];
        pidc_pkg::REG_KP_HEADING:
          cfg_r.kp_heading <= pwdata[pidc_pkg::GAIN_W-1:0];
        pidc_pkg::REG_KI_ALL:
          cfg_r.ki_all <= pwdata[pidc_pkg::GAIN_W-1:0];
        pidc_pkg::REG_KD_HORIZONTAL:
          cfg_r.kd_horizontal <= pwdata[pidc_pkg::GAIN_W-1:0];
        pidc_pkg::REG_KD_VERTICAL_HEADING:
          cfg_r.kd_vertical_heading <= pwdata[pidc_pkg::GAIN_W-1:0];
        pidc_pkg::REG_INTEGRAL_LIMIT:
          cfg_r.integral_limit <= pwdata[pidc_pkg::LIM_W-1:0];
        pidc_pkg::REG_OUTPUT_LIMIT:
          cfg_r.output_limit <= pwdata[pidc_pkg::LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      pidc_pkg::REG_KP_HORIZONTAL:       prdata = pidc_pkg::CFG_DW'(cfg_r.kp_horizontal);
      pidc_pkg::REG_KP_VERTICAL:         prdata = pidc_pkg::CFG_DW'(cfg_r.kp_vertical);
      pidc_pkg::REG_KP_HEADING:          prdata = pidc_pkg::CFG_DW'(cfg_r.kp_heading);
      pidc_pkg::REG_KI_ALL:              prdata = pidc_pkg::CFG_DW'(cfg_r.ki_all);
      pidc_pkg::REG_KD_HORIZONTAL:       prdata = pidc_pkg::CFG_DW'(cfg_r.kd_horizontal);
      pidc_pkg::REG_KD_VERTICAL_HEADING: prdata = pidc_pkg::CFG_DW'(cfg_r.kd_vertical_heading);
      pidc_pkg::REG_INTEGRAL_LIMIT:      prdata = pidc_pkg::CFG_DW'(cfg_r.integral_limit);
      pidc_pkg::REG_OUTPUT_LIMIT:        prdata = pidc_pkg::CFG_DW'(cfg_r.output_limit);
      default:                           prdata = '0;
    endcase
  end

endmodule

// ----- src/pidc_datapath.sv -----
// Datapath of the PID controller: input and output registers, the per-axis
// integral and last-error store, one shared multiplier and a radix-2 divider.
// Depends on pidc_pkg; driven by commands from pidc_ctrl.
module pidc_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pidc_pkg::cmd_t             cmd,
  output pidc_pkg::stat_t            stat,
  input  pidc_pkg::cfg_t             cfg,
  input  logic [pidc_pkg::IN_W-1:0]  in_data,
  output logic [pidc_pkg::OUT_W-1:0] out_data
);

  localparam int VW = pidc_pkg::VAL_W;
  localparam int EW = VW + 3;
  localparam int AW = pidc_pkg::ACC_W;
  localparam logic signed [EW-1:0] PI_E     = EW'(pidc_pkg::PI_Q);
  localparam logic signed [EW-1:0] TWO_PI_E = EW'(pidc_pkg::TWO_PI_Q);
  localparam logic signed [AW-1:0] S_MAX    = AW'((64'sd1 <<< (VW - 1)) - 64'sd1);
  localparam logic signed [AW-1:0] S_MIN    = -AW'(64'sd1 <<< (VW - 1));

  logic signed [VW-1:0] meas_r   [pidc_pkg::AXES];
  logic signed [VW-1:0] target_r [pidc_pkg::AXES];
  logic signed [VW-1:0] integ_store_r [pidc_pkg::AXES];
  logic signed [VW-1:0] prev_err_r    [pidc_pkg::AXES];
  logic signed [VW-1:0] drive_r  [pidc_pkg::AXES];
  logic [pidc_pkg::DT_W-1:0] dt_r;
  logic [pidc_pkg::OUT_W-1:0] out_data_r;

  logic signed [VW-1:0] err_r;
  logic signed [VW-1:0] integ_r;
  logic signed [VW-1:0] deriv_r;
  logic signed [pidc_pkg::PROD_W-1:0] prod_r;
  logic signed [AW-1:0] acc_r;
  logic [pidc_pkg::DIV_W-1:0] dvd_r;
  logic [VW-1:0] rem_r;
  logic diff_neg_r;
  logic diff_zero_r;

  logic yaw;
  logic vert;
  logic signed [EW-1:0] e_raw, e_wrap1, e_wrap2;
  logic signed [VW-1:0] err_sat;
  logic signed [VW:0]   diff;
  logic [VW:0]          diff_mag;
  logic [VW-1:0]        rem_sh;
  logic [VW:0]          trial;
  logic signed [VW-1:0] deriv_w;
  logic signed [VW-1:0] mul_a;
  logic [pidc_pkg::DT_W-1:0] mul_b;
  logic signed [VW-1:0] mul_bs;
  logic signed [pidc_pkg::SHP_W-1:0] shp;
  logic signed [AW-1:0] shp_e;
  logic signed [AW-1:0] isum, ilim_e, integ_cl;
  logic signed [AW-1:0] olim_e, drv_cl, drv_sat;
  logic [pidc_pkg::GAIN_W-1:0] kp_sel, kd_sel;

  assign stat.dt_zero = (dt_r == '0);
  assign out_data     = out_data_r;

  assign yaw  = (cmd.axis == pidc_pkg::AXIS_W'(pidc_pkg::AXES - 1));
  assign vert = (cmd.axis == pidc_pkg::AXIS_W'(pidc_pkg::AXES - 2));

  always_comb begin
    kp_sel = yaw ? cfg.kp_heading : (vert ? cfg.kp_vertical : cfg.kp_horizontal);
    kd_sel = (yaw || vert) ? cfg.kd_vertical_heading : cfg.kd_horizontal;
  end

  // Error with one conditional yaw wrap in each direction, then saturated to the value range.
  always_comb begin
    e_raw   = EW'(target_r[cmd.axis]) - EW'(meas_r[cmd.axis]);
    e_wrap1 = e_raw;
    if (yaw && (e_raw >= PI_E)) begin
      e_wrap1 = e_raw - TWO_PI_E;
    end
    e_wrap2 = e_wrap1;
    if (yaw && (e_wrap1 <= -PI_E)) begin
      e_wrap2 = e_wrap1 + TWO_PI_E;
    end
    if (AW'(e_wrap2) > S_MAX) begin
      err_sat = VW'(S_MAX);
    end else if (AW'(e_wrap2) < S_MIN) begin
      err_sat = VW'(S_MIN);
    end else begin
      err_sat = VW'(e_wrap2);
    end
  end

  always_comb begin
    diff     = (VW + 1)'(err_r) - (VW + 1)'(prev_err_r[cmd.axis]);
    diff_mag = diff[VW] ? (VW + 1)'(-diff) : (VW + 1)'(diff);
    rem_sh   = {rem_r[VW-2:0], dvd_r[pidc_pkg::DIV_W-1]};
    trial    = {1'b0, rem_sh} - (VW + 1)'(dt_r);
  end

  always_comb begin
    deriv_w = '0;
    if (stat.dt_zero) begin
      if (diff_zero_r) begin
        deriv_w = '0;
      end else if (diff_neg_r) begin
        deriv_w = -VW'(S_MAX);
      end else begin
        deriv_w = VW'(S_MAX);
      end
    end else if (diff_neg_r) begin
      if (dvd_r > pidc_pkg::DIV_W'(-S_MIN)) begin
        deriv_w = VW'(S_MIN);
      end else begin
        deriv_w = VW'(~dvd_r + 1'b1);
      end
    end else begin
      if (dvd_r > pidc_pkg::DIV_W'(S_MAX)) begin
        deriv_w = VW'(S_MAX);
      end else begin
        deriv_w = VW'(dvd_r);
      end
    end
  end

  always_comb begin
    mul_a = err_r;
    mul_b = dt_r;
    case (cmd.mul_sel)
      pidc_pkg::MUL_ERR_DT: begin
        mul_a = err_r;
        mul_b = dt_r;
      end
      pidc_pkg::MUL_ERR_KP: begin
        mul_a = err_r;
        mul_b = pidc_pkg::DT_W'(kp_sel);
      end
      pidc_pkg::MUL_INT_KI: begin
        mul_a = integ_r;
        mul_b = pidc_pkg::DT_W'(cfg.ki_all);
      end
      pidc_pkg::MUL_DER_KD: begin
        mul_a = deriv_r;
        mul_b = pidc_pkg::DT_W'(kd_sel);
      end
      default: begin
        mul_a = err_r;
        mul_b = dt_r;
      end
    endcase
    mul_bs = signed'({1'b0, mul_b});
  end

  always_comb begin
    shp      = pidc_pkg::SHP_W'(prod_r >>> pidc_pkg::FRAC_BITS);
    shp_e    = AW'(shp);
    ilim_e   = AW'(cfg.integral_limit);
    olim_e   = AW'(cfg.output_limit);
    isum     = AW'(integ_store_r[cmd.axis]) + shp_e;
    integ_cl = isum;
    if (isum > ilim_e) begin
      integ_cl = ilim_e;
    end else if (isum < -ilim_e) begin
      integ_cl = -ilim_e;
    end
    drv_cl = acc_r;
    if (!yaw && (acc_r > olim_e)) begin
      drv_cl = olim_e;
    end else if (!yaw && (acc_r < -olim_e)) begin
      drv_cl = -olim_e;
    end
    drv_sat = drv_cl;
    if (drv_cl > S_MAX) begin
      drv_sat = S_MAX;
    end else if (drv_cl < S_MIN) begin
      drv_sat = S_MIN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pidc_pkg::AXES; i++) begin
        integ_store_r[i] <= '0;
        prev_err_r[i]    <= '0;
      end
    end else if (cmd.axis_done) begin
      integ_store_r[cmd.axis] <= integ_r;
      prev_err_r[cmd.axis]    <= err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      for (int i = 0; i < pidc_pkg::AXES; i++) begin
        meas_r[i]   <= in_data[VW*i +: VW];
        target_r[i] <= in_data[VW*(pidc_pkg::AXES + i) +: VW];
      end
      dt_r <= in_data[2*VW*pidc_pkg::AXES +: pidc_pkg::DT_W];
    end
    if (cmd.err_cap) begin
      err_r <= err_sat;
    end
    if (cmd.mul_go) begin
      prod_r <= mul_a * mul_bs;
    end
    if (cmd.integ_upd) begin
      integ_r <= VW'(integ_cl);
    end
    if (cmd.div_init) begin
      diff_neg_r  <= diff[VW];
      diff_zero_r <= (diff == '0);
      dvd_r       <= {diff_mag[VW-1:0], pidc_pkg::FRAC_BITS'(0)};
      rem_r       <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[pidc_pkg::DIV_W-2:0], ~trial[VW]};
      if (!trial[VW]) begin
        rem_r <= trial[VW-1:0];
      end else begin
        rem_r <= rem_sh;
      end
    end
    if (cmd.deriv_fin) begin
      deriv_r <= deriv_w;
    end
    if (cmd.acc_load) begin
      acc_r <= shp_e;
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + shp_e;
    end
    if (cmd.axis_done) begin
      drive_r[cmd.axis] <= VW'(drv_sat);
    end
    if (cmd.out_load) begin
      for (int i = 0; i < pidc_pkg::AXES; i++) begin
        out_data_r[VW*i +: VW] <= drive_r[i];
      end
    end
  end

endmodule

// ----- src/pidc_ctrl.sv -----
// Sequencer of the PID controller: walks the axes one at a time through
// error, integral, proportional, divide (skipped at zero elapsed time), derivative and output steps.
// Depends on pidc_pkg; drives pidc_datapath through cmd_t.
module pidc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  pidc_pkg::stat_t stat,
  output pidc_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_MUL_DT,
    S_INTEG,
    S_ACC_P,
    S_ACC_I,
    S_DIV,
    S_DERIV,
    S_MUL_D,
    S_ACC_D,
    S_STORE,
    S_DONE
  } state_t;

  localparam logic [pidc_pkg::AXIS_W-1:0] LAST_AXIS = pidc_pkg::AXIS_W'(pidc_pkg::AXES - 1);

  state_t                      state_r, state_nxt;
  logic [pidc_pkg::AXIS_W-1:0] axis_r, axis_nxt;
  logic [pidc_pkg::DCNT_W-1:0] cnt_r, cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.axis      = axis_r;
    cmd.mul_sel   = pidc_pkg::MUL_ERR_DT;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          axis_nxt    = '0;
          state_nxt   = S_ERR;
        end
      end
      S_ERR: begin
        cmd.err_cap = 1'b1;
        state_nxt   = S_MUL_DT;
      end
      S_MUL_DT: begin
        cmd.mul_go   = 1'b1;
        cmd.mul_sel  = pidc_pkg::MUL_ERR_DT;
        cmd.div_init = 1'b1;
        state_nxt    = S_INTEG;
      end
      S_INTEG: begin
        cmd.integ_upd = 1'b1;
        cmd.mul_go    = 1'b1;
        cmd.mul_sel   = pidc_pkg::MUL_ERR_KP;
        state_nxt     = S_ACC_P;
      end
      S_ACC_P: begin
        cmd.acc_load = 1'b1;
        cmd.mul_go   = 1'b1;
        cmd.mul_sel  = pidc_pkg::MUL_INT_KI;
        state_nxt    = S_ACC_I;
      end
      S_ACC_I: begin
        cmd.acc_add = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = stat.dt_zero ? S_DERIV : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == pidc_pkg::DCNT_W'(pidc_pkg::DIV_W - 1)) begin
          state_nxt = S_DERIV;
        end
      end
      S_DERIV: begin
        cmd.deriv_fin = 1'b1;
        state_nxt     = S_MUL_D;
      end
      S_MUL_D: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = pidc_pkg::MUL_DER_KD;
        state_nxt   = S_ACC_D;
      end
      S_ACC_D: begin
        cmd.acc_add = 1'b1;
        state_nxt   = S_STORE;
      end
      S_STORE: begin
        cmd.axis_done = 1'b1;
        if (axis_r == LAST_AXIS) begin
          state_nxt = S_DONE;
        end else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = S_ERR;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("Result register loaded while a beat is still waiting.");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r < pidc_pkg::DCNT_W'(pidc_pkg::DIV_W)))
    else $error("Divider ran past its step count.");

  a_start_axis0: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_ERR && axis_r == '0))
    else $error("Accepted beat did not start at the first axis.");

  a_last_axis: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.axis_done && axis_r == LAST_AXIS) |=> (state_r == S_DONE))
    else $error("Last axis finished without moving to result hand-off.");

endmodule

// ----- src/four_axis_pid_position_controller.sv -----
// Four-axis PID position controller (x, y, z, yaw), signed Q16.16.
// Usage: one input beat on the in_ stream carries the measured pose, the
// target pose and the elapsed time; one output beat on the out_ stream
// carries the four drive commands. Gains and limits are set through the
// cfg_ APB port while the block is idle; pready is always high.
// The axes are worked one after another by a single multiplier and a
// one-bit-per-cycle divider for the derivative, which runs only when the
// elapsed time is nonzero. A new input beat is accepted only when the
// previous one has been worked through.
// The result sits in an output register; the next input beat is accepted
// while it waits, and the block holds its finished result if the receiver
// stalls. Reset clears the integrals and last errors to zero, loads the
// default gains and limits, and drops out_tvalid.
// Depends on pidc_pkg, pidc_cfg_regs, pidc_ctrl and pidc_datapath.
module four_axis_pid_position_controller (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // meas_x, meas_y, meas_z, meas_heading, target_x, target_y, target_z,
  // target_heading, elapsed_time, one zero pad bit
  input  logic [pidc_pkg::IN_W-1:0]   in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // drive_x, drive_y, drive_z, drive_heading
  output logic [pidc_pkg::OUT_W-1:0]  out_tdata,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [pidc_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [pidc_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [pidc_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  pidc_pkg::cfg_t  cfg;
  pidc_pkg::cmd_t  cmd;
  pidc_pkg::stat_t stat;

  assign cfg_pready = 1'b1;

  pidc_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  pidc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  pidc_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .cfg      (cfg),
    .in_data  (in_tdata),
    .out_data (out_tdata)
  );

endmodule

// ----- sim/four_axis_pid_position_controller_tb.sv -----
// Self-checking testbench for the four-axis PID position controller.
// Holds a cycle-free predictor of the drive commands in a small tracker class,
// drives the in_, out_ and cfg_ ports with plain tasks. Depends on pidc_pkg.
module four_axis_pid_position_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     AXES      = pidc_pkg::AXES;
  localparam int     FRAC_BITS = pidc_pkg::FRAC_BITS;
  localparam int     VAL_W     = pidc_pkg::VAL_W;
  localparam int     DT_W      = pidc_pkg::DT_W;
  localparam int     GAIN_W    = pidc_pkg::GAIN_W;
  localparam int     LIM_W     = pidc_pkg::LIM_W;
  localparam int     IN_W      = pidc_pkg::IN_W;
  localparam int     OUT_W     = pidc_pkg::OUT_W;
  localparam int     CFG_AW    = pidc_pkg::CFG_AW;
  localparam int     CFG_DW    = pidc_pkg::CFG_DW;
  localparam int     NUM_REGS  = pidc_pkg::NUM_REGS;
  localparam longint PI_Q      = pidc_pkg::PI_Q;
  localparam longint TWO_PI_Q  = pidc_pkg::TWO_PI_Q;

  typedef pidc_pkg::reg_idx_t reg_idx_t;

  localparam int          Q_ONE = 1 << FRAC_BITS;
  localparam logic [31:0] S_MAX = 32'h7fff_ffff;
  localparam logic [31:0] S_MIN = 32'h8000_0000;
  localparam int          PHASES = 7;
  localparam int          POSES_PER_PHASE = 160;
  localparam int          LONG_HOLD_CYCLES = 3000;
  localparam int          PENDING_DEPTH = 16;

  class pid_drive_tracker;
    longint kp_h, kp_v, kp_yaw, ki, kd_h, kd_vy, int_lim, out_lim;
    longint integ_acc[AXES];
    longint last_err[AXES];
    logic [OUT_W-1:0] expected_drives[PENDING_DEPTH];
    int head, tail, pending;
    string field_names[AXES] = '{"drive_x", "drive_y", "drive_z", "drive_heading"};
    int mismatches, poses_seen, drives_checked, zero_dt_steps, yaw_wraps, gain_writes;

    function new();
      kp_h = 131072;
      kp_v = 65536;
      kp_yaw = 65536;
      ki = 3277;
      kd_h = 98304;
      kd_vy = 0;
      int_lim = 65536;
      out_lim = 65536;
      head = 0;
      tail = 0;
      pending = 0;
      foreach (integ_acc[i]) begin
        integ_acc[i] = 0;
        last_err[i] = 0;
      end
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_gain(reg_idx_t idx, logic [CFG_DW-1:0] value);
      longint g, lim;
      g = value[GAIN_W-1:0];
      lim = value[LIM_W-1:0];
      gain_writes++;
      case (idx)
        pidc_pkg::REG_KP_HORIZONTAL:       kp_h = g;
        pidc_pkg::REG_KP_VERTICAL:         kp_v = g;
        pidc_pkg::REG_KP_HEADING:          kp_yaw = g;
        pidc_pkg::REG_KI_ALL:              ki = g;
        pidc_pkg::REG_KD_HORIZONTAL:       kd_h = g;
        pidc_pkg::REG_KD_VERTICAL_HEADING: kd_vy = g;
        pidc_pkg::REG_INTEGRAL_LIMIT:      int_lim = lim;
        pidc_pkg::REG_OUTPUT_LIMIT:        out_lim = lim;
        default: ;
      endcase
    endfunction

    function void note_pose(logic [IN_W-1:0] beat);
      logic [OUT_W-1:0] drives;
      longint dt, err, integ, diff, deriv, drive, kp, kd, lo32, hi32;
      int meas, tgt;
      lo32 = -64'sd2147483648;
      hi32 = 64'sd2147483647;
      dt = beat[2*AXES*VAL_W +: DT_W];
      poses_seen++;
      if (dt == 0) zero_dt_steps++;
      for (int i = 0; i < AXES; i++) begin
        if (i == AXES - 1) begin
          kp = kp_yaw;
          kd = kd_vy;
        end else if (i == AXES - 2) begin
          kp = kp_v;
          kd = kd_vy;
        end else begin
          kp = kp_h;
          kd = kd_h;
        end
        meas = beat[i*VAL_W +: VAL_W];
        tgt = beat[(AXES+i)*VAL_W +: VAL_W];
        err = longint'(tgt) - longint'(meas);
        if (i == AXES - 1) begin
          if (err >= PI_Q || err <= -PI_Q) yaw_wraps++;
          if (err >= PI_Q) err -= TWO_PI_Q;
          if (err <= -PI_Q) err += TWO_PI_Q;
        end
        err = clamp(err, lo32, hi32);
        integ = clamp(integ_acc[i] + ((err * dt) >>> FRAC_BITS), -int_lim, int_lim);
        diff = err - last_err[i];
        if (dt == 0)
          deriv = (diff > 0) ? hi32 : ((diff < 0) ? -hi32 : 0);
        else
          deriv = clamp((diff * (64'sd1 <<< FRAC_BITS)) / dt, lo32, hi32);
        drive = ((err * kp) >>> FRAC_BITS) + ((integ * ki) >>> FRAC_BITS)
              + ((deriv * kd) >>> FRAC_BITS);
        if (i != AXES - 1) drive = clamp(drive, -out_lim, out_lim);
        drive = clamp(drive, lo32, hi32);
        integ_acc[i] = integ;
        last_err[i] = err;
        drives[i*VAL_W +: VAL_W] = drive[VAL_W-1:0];
      end
      if (pending == PENDING_DEPTH) begin
        $error("Too many pose beats waiting for their drive beats.");
        mismatches++;
      end else begin
        expected_drives[tail] = drives;
        tail = (tail + 1) % PENDING_DEPTH;
        pending++;
      end
    endfunction

    function void check_drive(logic [OUT_W-1:0] beat);
      logic [OUT_W-1:0] want;
      if (pending == 0) begin
        $error("Drive beat %h arrived with no pose waiting for it.", beat);
        mismatches++;
        return;
      end
      want = expected_drives[head];
      head = (head + 1) % PENDING_DEPTH;
      pending--;
      drives_checked++;
      for (int i = 0; i < AXES; i++) begin
        if (beat[i*VAL_W +: VAL_W] !== want[i*VAL_W +: VAL_W]) begin
          $error("%s: expected %0d, got %0d", field_names[i],
                 $signed(want[i*VAL_W +: VAL_W]), $signed(beat[i*VAL_W +: VAL_W]));
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_W-1:0]     in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_W-1:0]    out_tdata;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CFG_AW-1:0]   cfg_paddr;
  logic [CFG_DW-1:0]   cfg_pwdata;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  pid_drive_tracker tracker = new();
  bit send_idle = 1;
  bit ready_idle = 1;
  bit hold_long = 0;
  int long_holds = 0;
  logic [31:0] setpoint[AXES];

  four_axis_pid_position_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("four_axis_pid_position_controller_tb NOT OK");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)
        tracker.write_gain(reg_idx_t'(cfg_paddr[CFG_AW-1:2]), cfg_pwdata);
      if (in_tvalid && in_tready) tracker.note_pose(in_tdata);
      if (out_tvalid && out_tready) tracker.check_drive(out_tdata);
    end
  end

  initial begin
    out_tready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_long) begin
        hold_long = 0;
        long_holds++;
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else if (ready_idle && $urandom_range(0, 1)) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  function automatic logic [IN_W-1:0] pose_beat(logic [31:0] mx, my, mz, mh,
                                                 logic [31:0] tx, ty, tz, th,
                                                 logic [DT_W-1:0] dt);
    logic [IN_W-1:0] b;
    b = IN_W'({dt, th, tz, ty, tx, mh, mz, my, mx});
    return b;
  endfunction

  function automatic logic [31:0] small_signed(int unsigned span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 19))
      0:       return $urandom();
      1:       case ($urandom_range(0, 3))
                 0:       return S_MAX;
                 1:       return S_MIN;
                 2:       return 32'h0;
                 default: return 32'hffff_ffff;
               endcase
      2, 3:    return small_signed(1000 * Q_ONE);
      default: return small_signed(8 * Q_ONE);
    endcase
  endfunction

  function automatic logic [31:0] rand_angle();
    if ($urandom_range(0, 9) == 0) return rand_coord();
    return small_signed(4 * Q_ONE);
  endfunction

  function automatic logic [DT_W-1:0] rand_dt();
    logic [DT_W-1:0] v;
    case ($urandom_range(0, 19))
      0, 1:    v = '0;
      2:       v = DT_W'(1);
      3:       v = '1;
      4, 5:    v = DT_W'($urandom());
      default: v = DT_W'($urandom_range(1, 6554));
    endcase
    return v;
  endfunction

  task automatic send_pose(logic [IN_W-1:0] beat);
    int gap;
    gap = (send_idle && $urandom_range(0, 2) == 0) ? $urandom_range(1, 19) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= beat;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_random_poses(int count);
    logic [IN_W-1:0] b;
    for (int n = 0; n < count; n++) begin
      b = '0;
      for (int i = 0; i < AXES; i++) begin
        if ($urandom_range(0, 1))
          setpoint[i] = (i == AXES - 1) ? rand_angle() : rand_coord();
        b[i*VAL_W +: VAL_W] = (i == AXES - 1) ? rand_angle() : rand_coord();
        b[(AXES+i)*VAL_W +: VAL_W] = setpoint[i];
      end
      b[2*AXES*VAL_W +: DT_W] = rand_dt();
      send_pose(b);
    end
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (tracker.pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [CFG_DW-1:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_gains(int phase);
    reg_idx_t idx;
    logic [CFG_DW-1:0] v;
    for (int r = 0; r < NUM_REGS; r++) begin
      idx = reg_idx_t'(r);
      case (phase)
        1:       v = 32'hffff_ffff;
        2:       v = '0;
        4:       v = $urandom();
        default: v = (idx == pidc_pkg::REG_INTEGRAL_LIMIT || idx == pidc_pkg::REG_OUTPUT_LIMIT)
                     ? $urandom_range(0, 10 * Q_ONE) : $urandom_range(0, 4 * Q_ONE);
      endcase
      cfg_write(idx, v);
    end
  endtask

  initial begin
    int pi_q;
    pi_q = int'(PI_Q);
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    foreach (setpoint[i]) setpoint[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Hand-picked poses under the reset gains.
    send_pose(pose_beat(0, 0, 0, 0, 0, 0, 0, 0, 655));
    send_pose(pose_beat(0, 0, 0, 0, Q_ONE, -Q_ONE, Q_ONE / 2, Q_ONE / 4, 655));
    send_pose(pose_beat(0, 0, 0, 0, 2 * Q_ONE, -2 * Q_ONE, Q_ONE, Q_ONE, 0));
    send_pose(pose_beat(0, 0, 0, 0, -Q_ONE, Q_ONE, -Q_ONE, -Q_ONE, 0));
    send_pose(pose_beat(0, 0, 0, 0, -Q_ONE, Q_ONE, -Q_ONE, -Q_ONE, 0));
    send_pose(pose_beat(0, 0, 0, 0, 3 * Q_ONE, -3 * Q_ONE, 2 * Q_ONE, 0, 1));
    send_pose(pose_beat(0, 0, 0, 0, Q_ONE, Q_ONE, -Q_ONE, Q_ONE, '1));
    send_pose(pose_beat(S_MIN, S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, S_MAX, S_MAX, 655));
    send_pose(pose_beat(S_MAX, S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN, S_MIN, 0));
    send_pose(pose_beat(0, 0, 0, 0, 0, 0, 0, pi_q, 655));
    send_pose(pose_beat(0, 0, 0, 0, 0, 0, 0, -pi_q, 655));
    send_pose(pose_beat(0, 0, 0, 0, 0, 0, 0, pi_q - 1, 655));
    send_pose(pose_beat(0, 0, 0, 0, 0, 0, 0, 1 - pi_q, 655));
    send_pose(pose_beat(0, 0, 0, -pi_q, 0, 0, 0, 2 * pi_q, 655));
    send_pose(pose_beat(0, 0, 0, pi_q, 0, 0, 0, -2 * pi_q, 655));
    send_pose(pose_beat(0, 0, 0, pi_q, 0, 0, 0, -pi_q, 655));
    repeat (4) send_pose(pose_beat(0, 0, 0, 0, 2 * Q_ONE, -2 * Q_ONE, 2 * Q_ONE, Q_ONE, Q_ONE));
    send_pose(pose_beat(Q_ONE, -Q_ONE, 0, 0, -Q_ONE, Q_ONE, 0, 0, 0));
    in_tvalid <= 1'b0;
    wait_drained();

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) program_gains(phase);
      if (phase == PHASES - 2) hold_long = 1;
      if (phase == PHASES - 1) begin
        send_idle = 0;
        ready_idle = 0;
      end
      send_random_poses(POSES_PER_PHASE);
      wait_drained();
    end

    repeat (300) @(posedge clk);
    $display("Covered %0d pose beats and %0d drive beats over %0d gain settings (%0d writes).",
             tracker.poses_seen, tracker.drives_checked, PHASES, tracker.gain_writes);
    $display("Saw %0d zero elapsed-time steps, %0d yaw wraps and %0d long output stalls.",
             tracker.zero_dt_steps, tracker.yaw_wraps, long_holds);
    if (tracker.mismatches == 0 && tracker.pending == 0)
      $display("four_axis_pid_position_controller_tb OK");
    else
      $display("four_axis_pid_position_controller_tb NOT OK");
    $finish;
  end

endmodule

// ----- files.f -----
src/pidc_pkg.sv
src/pidc_cfg_regs.sv
src/pidc_datapath.sv
src/pidc_ctrl.sv
src/four_axis_pid_position_controller.sv
sim/four_axis_pid_position_controller_tb.sv
